### rtl/csro_pkg.sv
// Shared types and constants for the clock-synced ramp oscillator.
package csro_pkg;

    // Widths fixed by the item and register fields
    localparam int CNT_W = 7;
    localparam int IDX_W = 4;
    localparam int CFG_DW = 24;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_BOTTOM_MV       = 4'd0;
    localparam logic [IDX_W-1:0] REG_TOP_MV          = 4'd1;
    localparam logic [IDX_W-1:0] REG_FREE_INCREMENT  = 4'd2;
    localparam logic [IDX_W-1:0] REG_RUN_DIRECTION   = 4'd3;
    localparam logic [IDX_W-1:0] REG_PHASE_SHIFT     = 4'd4;
    localparam logic [IDX_W-1:0] REG_CLOCK_LOCKED    = 4'd5;
    localparam logic [IDX_W-1:0] REG_KEEP_OFFSET     = 4'd6;
    localparam logic [IDX_W-1:0] REG_BEAT_MULTIPLIER = 4'd7;

    // Request modes
    localparam logic [1:0] MODE_RUN    = 2'd0;
    localparam logic [1:0] MODE_SET    = 2'd1;
    localparam logic [1:0] MODE_NUDGE  = 2'd2;
    localparam logic [1:0] MODE_RESYNC = 2'd3;

    // Configuration register file contents
    typedef struct packed {
        logic signed [15:0] bottom_mv;
        logic signed [15:0] top_mv;
        logic [23:0]        free_increment;
        logic [1:0]         run_direction;
        logic [23:0]        phase_shift;
        logic               clock_locked;
        logic               keep_offset;
        logic [23:0]        beat_multiplier;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // latch request fields
        logic dec;    // decode: set/nudge phase, free step, range
        logic mlo;    // multiply beat_multiplier by low half of beat time
        logic mhi;    // multiply by high half, keep low product
        logic cp;     // finish clock phase, multiply for locked rate
        logic capt;   // capture sync offset
        logic err;    // phase error
        logic gain;   // scale error by loop gain
        logic step;   // form locked step
        logic issue;  // advance phase and start one sample
        logic last;   // sample issued is the last of the block
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0]       mode;
        logic [CNT_W-1:0] count;   // clamped block length
        logic             adv;     // sample pipeline can move
    } stat_t;

endpackage

### rtl/csro_cfg.sv
// Configuration register file for the ramp oscillator.
module csro_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [csro_pkg::IDX_W-1:0]    cfg_addr,
    input  logic [csro_pkg::CFG_DW-1:0]   cfg_data,
    output csro_pkg::cfg_t                cfg
);
    import csro_pkg::*;

    cfg_t cfg_reg;
    logic wr;

    assign cfg_ready = 1'b1;
    assign wr = cfg_valid && cfg_ready;
    assign cfg = cfg_reg;

    // Register writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bottom_mv       <= -16'sd5000;
            cfg_reg.top_mv          <= 16'sd5000;
            cfg_reg.free_increment  <= 24'd1000;
            cfg_reg.run_direction   <= 2'b00;
            cfg_reg.phase_shift     <= 24'd0;
            cfg_reg.clock_locked    <= 1'b0;
            cfg_reg.keep_offset     <= 1'b1;
            cfg_reg.beat_multiplier <= 24'd65536;
        end
        else if (wr)
        begin
            case (cfg_addr)
                REG_BOTTOM_MV:       cfg_reg.bottom_mv       <= cfg_data[15:0];
                REG_TOP_MV:          cfg_reg.top_mv          <= cfg_data[15:0];
                REG_FREE_INCREMENT:  cfg_reg.free_increment  <= cfg_data;
                REG_RUN_DIRECTION:   cfg_reg.run_direction   <= cfg_data[1:0];
                REG_PHASE_SHIFT:     cfg_reg.phase_shift     <= cfg_data;
                REG_CLOCK_LOCKED:    cfg_reg.clock_locked    <= cfg_data[0];
                REG_KEEP_OFFSET:     cfg_reg.keep_offset     <= cfg_data[0];
                REG_BEAT_MULTIPLIER: cfg_reg.beat_multiplier <= cfg_data;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

### rtl/csro_ctrl.sv
// Sequencing state machine for the ramp oscillator.
module csro_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  csro_pkg::cfg_t  cfg,
    input  csro_pkg::stat_t stat,
    output csro_pkg::cmd_t  cmd
);
    import csro_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_MLO  = 4'd2;
    localparam logic [3:0] S_MHI  = 4'd3;
    localparam logic [3:0] S_CP   = 4'd4;
    localparam logic [3:0] S_CAPT = 4'd5;
    localparam logic [3:0] S_ERR  = 4'd6;
    localparam logic [3:0] S_GAIN = 4'd7;
    localparam logic [3:0] S_STEP = 4'd8;
    localparam logic [3:0] S_RUN  = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             dir_zero;
    logic             issue;

    assign dir_zero = (cfg.run_direction == 2'b00);
    assign in_ready = (state_reg == S_IDLE);
    assign issue    = (state_reg == S_RUN) && stat.adv;

    // Commands decoded from the state
    always_comb
    begin
        cmd       = '0;
        cmd.load  = in_valid && in_ready;
        cmd.dec   = (state_reg == S_DEC);
        cmd.mlo   = (state_reg == S_MLO);
        cmd.mhi   = (state_reg == S_MHI);
        cmd.cp    = (state_reg == S_CP);
        cmd.capt  = (state_reg == S_CAPT);
        cmd.err   = (state_reg == S_ERR);
        cmd.gain  = (state_reg == S_GAIN);
        cmd.step  = (state_reg == S_STEP);
        cmd.issue = issue;
        cmd.last  = (cnt_reg == CNT_W'(1));
    end

    // Next state and remaining sample count
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                cnt_next = stat.count;
                case (stat.mode)
                    MODE_RUN:
                    begin
                        if (stat.count == '0)
                            state_next = S_IDLE;
                        else if (dir_zero || !cfg.clock_locked)
                            state_next = S_RUN;
                        else
                            state_next = S_MLO;
                    end
                    MODE_SET, MODE_NUDGE:
                        state_next = (cfg.clock_locked && cfg.keep_offset) ? S_MLO : S_IDLE;
                    MODE_RESYNC:
                        state_next = S_MLO;
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_MLO:  state_next = S_MHI;
            S_MHI:  state_next = S_CP;
            S_CP:   state_next = (stat.mode == MODE_RUN) ? S_ERR : S_CAPT;
            S_CAPT: state_next = S_IDLE;
            S_ERR:  state_next = S_GAIN;
            S_GAIN: state_next = S_STEP;
            S_STEP: state_next = S_RUN;
            S_RUN:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### rtl/csro_dp.sv
// Phase accumulator, lock arithmetic and ramp scaling pipeline.
module csro_dp #(
    parameter int MAX_BLOCK  = 64,
    parameter int PHASE_BITS = 24,
    parameter int LOOP_GAIN  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  csro_pkg::cfg_t                 cfg,
    input  csro_pkg::cmd_t                 cmd,
    input  logic [1:0]                     in_mode,
    input  logic [39:0]                    in_beat_time,
    input  logic [23:0]                    in_beat_increment,
    input  logic [csro_pkg::CNT_W-1:0]     in_sample_count,
    input  logic signed [24:0]             in_phase_value,
    output csro_pkg::stat_t                stat,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [15:0]             out_sample,
    output logic                           out_last
);
    import csro_pkg::*;

    localparam int PB = PHASE_BITS;
    localparam logic [PB-1:0]    HALF   = {1'b1, {(PB-1){1'b0}}};
    localparam logic [PB-1:0]    GAIN_V = PB'(LOOP_GAIN);
    localparam logic [CNT_W-1:0] MAX_N  = CNT_W'(MAX_BLOCK);

    // Q0.24 to phase format: left with zero fill or right truncating
    function automatic logic [PB-1:0] to_ph(input logic [23:0] v);
        logic [PB+23:0] w;
        w = {v, {PB{1'b0}}} >> 24;
        return w[PB-1:0];
    endfunction

    // Request fields
    logic [1:0]       mode_reg;
    logic [39:0]      bt_reg;
    logic [23:0]      binc_reg;
    logic [CNT_W-1:0] cnt_in_reg;
    logic [23:0]      pv_reg;

    // Phase state and lock arithmetic
    logic [PB-1:0] acc_reg, acc_next;
    logic [PB-1:0] so_reg;
    logic [47:0]   prod_reg;
    logic [39:0]   cp_reg;
    logic [PB-1:0] e_reg, rate_reg, g_reg, step_reg;
    logic [15:0]   mag_reg;
    logic          neg_reg;

    // Sample pipeline
    logic               p1_valid_reg, p1_last_reg;
    logic [PB-1:0]      p1_ph_reg;
    logic               p2_valid_reg, p2_last_reg;
    logic [PB+15:0]     p2_prod_reg;
    logic               out_valid_reg, out_last_reg;
    logic signed [15:0] out_reg;

    logic          adv;
    logic          dir_zero, dir_neg;
    logic [23:0]   mul_b;
    logic [47:0]   mul_p;
    logic [39:0]   cp_sum, cp_fin;
    logic [PB-1:0] cp_ph, so_eff, err_raw, err_dir;
    logic [2*PB-1:0] g_full;
    logic [PB-1:0] d_lock, step_lock;
    logic [PB-1:0] pv_ph, free_ph, shift_ph, free_step;
    logic [PB-1:0] acc_adv, ph_next;
    logic [16:0]   range17, range_abs;
    logic [PB+15:0] p1_prod;
    logic [PB+16:0] q_sum;
    logic [15:0]   q;

    assign adv      = !out_valid_reg || out_ready;
    assign dir_zero = (cfg.run_direction == 2'b00);
    assign dir_neg  = cfg.run_direction[1];

    assign stat.mode  = mode_reg;
    assign stat.count = (cnt_in_reg > MAX_N) ? MAX_N : cnt_in_reg;
    assign stat.adv   = adv;

    // Shared 24x24 multiplier: beat time halves, then beat increment
    always_comb
    begin
        if (cmd.mlo)
            mul_b = {4'b0, bt_reg[19:0]};
        else if (cmd.mhi)
            mul_b = {4'b0, bt_reg[39:20]};
        else
            mul_b = binc_reg;
    end
    assign mul_p = cfg.beat_multiplier * mul_b;

    // Clock phase: low 40 bits of the product, negated when running backward
    assign cp_sum = cp_reg + {prod_reg[19:0], 20'b0};
    assign cp_fin = dir_neg ? (40'd0 - cp_sum) : cp_sum;
    assign cp_ph  = dir_zero ? '0 : cp_reg[39 -: PB];

    // Phase error and step; only the value modulo one cycle matters
    assign so_eff    = cfg.keep_offset ? so_reg : '0;
    assign err_raw   = acc_reg - (cp_ph + so_eff);
    assign err_dir   = dir_neg ? ('0 - err_raw) : err_raw;
    assign g_full    = e_reg * GAIN_V;
    assign d_lock    = rate_reg - g_reg;
    assign step_lock = dir_neg ? ('0 - d_lock) : d_lock;

    assign pv_ph     = to_ph(pv_reg);
    assign free_ph   = to_ph(cfg.free_increment);
    assign shift_ph  = to_ph(cfg.phase_shift);
    assign free_step = dir_zero ? '0 : (dir_neg ? ('0 - free_ph) : free_ph);

    assign acc_adv = acc_reg + step_reg;
    assign ph_next = acc_adv + shift_ph;

    // Ramp span and magnitude
    assign range17   = {cfg.top_mv[15], cfg.top_mv} - {cfg.bottom_mv[15], cfg.bottom_mv};
    assign range_abs = range17[16] ? (17'd0 - range17) : range17;

    // Scaling
    assign p1_prod = p1_ph_reg * mag_reg;
    assign q_sum   = {1'b0, p2_prod_reg} + (PB+17)'(HALF);
    assign q       = q_sum[PB+15:PB];

    assign out_valid  = out_valid_reg;
    assign out_sample = out_reg;
    assign out_last   = out_last_reg;

    // Phase accumulator updates
    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.dec && mode_reg == MODE_SET)
            acc_next = pv_ph;
        else if (cmd.dec && mode_reg == MODE_NUDGE)
            acc_next = acc_reg + pv_ph;
        else if (cmd.issue)
            acc_next = acc_adv;
    end

    // Control state and phase state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= HALF;
            so_reg        <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (cmd.capt)
                so_reg <= acc_reg - cp_ph;
            if (adv)
            begin
                p1_valid_reg  <= cmd.issue;
                p2_valid_reg  <= p1_valid_reg;
                out_valid_reg <= p2_valid_reg;
            end
        end
    end

    // Request fields and lock arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= in_mode;
            bt_reg     <= in_beat_time;
            binc_reg   <= in_beat_increment;
            cnt_in_reg <= in_sample_count;
            pv_reg     <= in_phase_value[23:0];
        end
        if (cmd.dec)
        begin
            step_reg <= free_step;
            mag_reg  <= range_abs[15:0];
            neg_reg  <= range17[16];
        end
        if (cmd.mlo || cmd.mhi || cmd.cp)
            prod_reg <= mul_p;
        if (cmd.mhi)
            cp_reg <= prod_reg[39:0];
        if (cmd.cp)
            cp_reg <= cp_fin;
        if (cmd.err)
        begin
            e_reg    <= err_dir;
            rate_reg <= prod_reg[39 -: PB];
        end
        if (cmd.gain)
            g_reg <= g_full[PB-1:0];
        if (cmd.step)
            step_reg <= step_lock;
    end

    // Sample pipeline payload: phase, product, output
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_ph_reg    <= ph_next;
            p1_last_reg  <= cmd.last;
            p2_prod_reg  <= p1_prod;
            p2_last_reg  <= p1_last_reg;
            out_reg      <= neg_reg ? (cfg.bottom_mv - q) : (cfg.bottom_mv + q);
            out_last_reg <= p2_last_reg;
        end
    end

endmodule

### rtl/clock_synced_ramp_oscillator.sv
// Top level of the clock-synced ramp oscillator: registers, controller, datapath.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | mode in tuser; times and counts in tdata
//  m_*      | out       | m_tvalid/m_tready  | sample_mv in tdata, last_sample on tlast
//  cfg_*    | in        | cfg_valid/cfg_ready| register index and write data
//
// A request is decoded first. A locked run block then adds the steps of the shared
// 24x24 multiplier (two beat-time halves, beat increment), error, gain and step;
// then one sample per cycle unless the output stalls, through the phase, product
// and output registers. Set and nudge may add an offset capture; resync always does.
// Reset loads register defaults, half-cycle phase and zero sync offset.
// A stalled output holds the sample pipeline; the next request is taken once
// all samples of the block are issued.
module clock_synced_ramp_oscillator #(
    parameter int MAX_BLOCK  = 64,
    parameter int PHASE_BITS = 24,
    parameter int LOOP_GAIN  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [39:0] beat_time, [63:40] beat_increment, [70:64] sample_count,
    // [95:71] phase_value
    input  logic [95:0]                 s_tdata,
    // [1:0] mode
    input  logic [1:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [15:0] sample_mv
    output logic [15:0]                 m_tdata,
    output logic                        m_tlast,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [csro_pkg::IDX_W-1:0]  cfg_addr,
    input  logic [csro_pkg::CFG_DW-1:0] cfg_data
);
    import csro_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;
    logic signed [15:0] sample;

    csro_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    csro_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cfg      (cfg),
        .stat     (stat),
        .cmd      (cmd)
    );

    csro_dp #(
        .MAX_BLOCK  (MAX_BLOCK),
        .PHASE_BITS (PHASE_BITS),
        .LOOP_GAIN  (LOOP_GAIN)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .cmd               (cmd),
        .in_mode           (s_tuser),
        .in_beat_time      (s_tdata[39:0]),
        .in_beat_increment (s_tdata[63:40]),
        .in_sample_count   (s_tdata[70:64]),
        .in_phase_value    (s_tdata[95:71]),
        .stat              (stat),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_sample        (sample),
        .out_last          (m_tlast)
    );

    assign m_tdata = sample;

endmodule
